### src/tbl_pkg.sv
package tbl_pkg;

    localparam int GRID_DIM  = 64;
    localparam int CELLS     = GRID_DIM * GRID_DIM;
    localparam int CELL_AW   = $clog2(CELLS);
    localparam int MAX_COMP  = 2048;
    localparam int COMP_AW   = $clog2(MAX_COMP);
    localparam int LAB_W     = 12;

    localparam logic [1:0] OP_WRITE    = 2'd0;
    localparam logic [1:0] OP_RUN      = 2'd1;
    localparam logic [1:0] OP_READ_LAB = 2'd2;
    localparam logic [1:0] OP_READ_REC = 2'd3;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_THRESH = 2'd2;
    localparam logic [1:0] CFG_EIGHT  = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [5:0]         cell_x;
        logic [5:0]         cell_y;
        logic signed [15:0] sample;
        logic [11:0]        component_number;
    } t_in;

    typedef struct packed {
        logic               status;
        logic [11:0]        cell_label;
        logic [11:0]        component_count;
        logic [12:0]        area;
        logic signed [15:0] max_value;
        logic signed [27:0] value_sum;
        logic [18:0]        x_sum_doubled;
        logic [18:0]        y_sum_doubled;
        logic [5:0]         box_min_x;
        logic [5:0]         box_max_x;
        logic [5:0]         box_min_y;
        logic [5:0]         box_max_y;
    } t_out;

    typedef struct packed {
        logic [12:0]        area;
        logic signed [15:0] peak;
        logic signed [27:0] total;
        logic [18:0]        xs2;
        logic [18:0]        ys2;
        logic [5:0]         bx0;
        logic [5:0]         bx1;
        logic [5:0]         by0;
        logic [5:0]         by1;
    } t_rec;

    // neighbor step order: right, left, down, up, then the diagonals
    function automatic logic signed [1:0] step_dx(input logic [2:0] k);
        case (k)
            3'd0: step_dx = 2'sd1;
            3'd1: step_dx = -2'sd1;
            3'd2: step_dx = 2'sd0;
            3'd3: step_dx = 2'sd0;
            3'd4: step_dx = 2'sd1;
            3'd5: step_dx = 2'sd1;
            default: step_dx = -2'sd1;
        endcase
    endfunction

    function automatic logic signed [1:0] step_dy(input logic [2:0] k);
        case (k)
            3'd0: step_dy = 2'sd0;
            3'd1: step_dy = 2'sd0;
            3'd2: step_dy = 2'sd1;
            3'd3: step_dy = -2'sd1;
            3'd4: step_dy = 2'sd1;
            3'd5: step_dy = -2'sd1;
            3'd6: step_dy = 2'sd1;
            default: step_dy = -2'sd1;
        endcase
    endfunction

endpackage

### src/tbl_ram.sv
module tbl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### src/threshold_blob_labeling.sv
// write: stored on the input beat; cell or component read: the read address is taken with the beat,
//   the memory data then fills the output register once that register holds no unaccepted beat
// run: clears the label memory, then scans the cells in raster order; each labeled cell
//   is popped from the queue and its 4 or 8 neighbors are checked in turn, through the single
//   read port of the sample and label memories shared by the scan and the walk sequencer
// one input beat at a time; no input beat is taken while a run or read is in flight
// reset (synchronous, active low) clears control, registers, count; labels read as zero
module threshold_blob_labeling (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tbl_pkg::t_in       i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tbl_pkg::t_out      o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_RD_WAIT  = 4'd1;
    localparam logic [3:0] S_CLEAR    = 4'd2;
    localparam logic [3:0] S_SCAN_RD  = 4'd3;
    localparam logic [3:0] S_SCAN_CHK = 4'd4;
    localparam logic [3:0] S_POP      = 4'd5;
    localparam logic [3:0] S_POP_WAIT = 4'd6;
    localparam logic [3:0] S_CUR_WAIT = 4'd7;
    localparam logic [3:0] S_NB_ISSUE = 4'd8;
    localparam logic [3:0] S_NB_CHK   = 4'd9;
    localparam logic [3:0] S_REC_WR   = 4'd10;

    localparam int CAW = tbl_pkg::CELL_AW;

    logic [3:0]  r_state;
    logic [6:0]  r_cfg_w, r_cfg_h;
    logic signed [15:0] r_thr;
    logic        r_eight;
    logic [11:0] r_count;
    logic        r_ran;
    logic [CAW-1:0] r_clr;
    logic [5:0]  r_sx, r_sy;
    logic [CAW:0] r_head, r_tail;
    logic [5:0]  r_cx, r_cy;
    logic [2:0]  r_k;
    logic [11:0] r_lab;
    logic [CAW-1:0] r_na;
    tbl_pkg::t_rec r_rec;
    logic        r_out_valid;
    tbl_pkg::t_out r_out;
    logic [1:0]  r_op;
    logic [CAW-1:0] r_addr;
    logic [11:0] r_num;

    // memory ports
    logic                 smp_we;
    logic [CAW-1:0]       smp_waddr, smp_raddr;
    logic signed [15:0]   smp_rdata;
    logic                 lab_we;
    logic [CAW-1:0]       lab_waddr, lab_raddr;
    logic [11:0]          lab_wdata, lab_rdata;
    logic                 q_we;
    logic [CAW-1:0]       q_waddr, q_raddr, q_rdata;
    logic                 rec_we;
    logic [tbl_pkg::COMP_AW-1:0] rec_waddr, rec_raddr;
    tbl_pkg::t_rec        rec_rdata;

    // grid size saturated into 1..64
    logic [6:0] grid_w, grid_h;
    assign grid_w = (r_cfg_w == 7'd0) ? 7'd1 :
                    (r_cfg_w > 7'(tbl_pkg::GRID_DIM)) ? 7'(tbl_pkg::GRID_DIM) : r_cfg_w;
    assign grid_h = (r_cfg_h == 7'd0) ? 7'd1 :
                    (r_cfg_h > 7'(tbl_pkg::GRID_DIM)) ? 7'(tbl_pkg::GRID_DIM) : r_cfg_h;

    logic in_acc;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // scan position
    logic [CAW-1:0] scan_a;
    logic x_last, scan_last;
    assign scan_a    = {r_sy, r_sx};
    assign x_last    = ({1'b0, r_sx} + 7'd1) == grid_w;
    assign scan_last = x_last && (({1'b0, r_sy} + 7'd1) == grid_h);

    // neighbor address
    logic signed [7:0] nx, ny;
    logic nb_in, k_last;
    logic [CAW-1:0] na;
    assign nx = $signed({2'b00, r_cx}) + 8'(tbl_pkg::step_dx(r_k));
    assign ny = $signed({2'b00, r_cy}) + 8'(tbl_pkg::step_dy(r_k));
    assign nb_in = !nx[7] && !ny[7] && (nx[6:0] < grid_w) && (ny[6:0] < grid_h);
    assign na = {ny[5:0], nx[5:0]};
    assign k_last = r_k == (r_eight ? 3'd7 : 3'd3);

    // candidate cell test shared by scan and walk
    logic cand;
    assign cand = (lab_rdata == 12'd0) && (smp_rdata > r_thr);

    // component read validity
    logic rec_ok;
    assign rec_ok = (r_num != 12'd0) && (r_num <= r_count)
                    && ({1'b0, r_num} <= 13'(tbl_pkg::MAX_COMP));

    // result beat built from the read data
    tbl_pkg::t_out n_out;
    always_comb begin
        n_out                 = '0;
        n_out.component_count = r_count;
        if (r_op == tbl_pkg::OP_READ_LAB) begin
            n_out.cell_label = r_ran ? lab_rdata : 12'd0;
        end else if (!rec_ok) begin
            n_out.status = 1'b1;
        end else begin
            n_out.area          = rec_rdata.area;
            n_out.max_value     = rec_rdata.peak;
            n_out.value_sum     = rec_rdata.total;
            n_out.x_sum_doubled = rec_rdata.xs2;
            n_out.y_sum_doubled = rec_rdata.ys2;
            n_out.box_min_x     = rec_rdata.bx0;
            n_out.box_max_x     = rec_rdata.bx1;
            n_out.box_min_y     = rec_rdata.by0;
            n_out.box_max_y     = rec_rdata.by1;
        end
    end

    // memory port steering
    always_comb begin
        smp_we    = in_acc && (i_in_data.opcode == tbl_pkg::OP_WRITE);
        smp_waddr = {i_in_data.cell_y, i_in_data.cell_x};
        case (r_state)
            S_POP_WAIT: smp_raddr = q_rdata;
            S_NB_ISSUE: smp_raddr = na;
            default:    smp_raddr = scan_a;
        endcase

        lab_we    = 1'b0;
        lab_waddr = r_clr;
        lab_wdata = 12'd0;
        q_we      = 1'b0;
        q_waddr   = r_tail[CAW-1:0];
        case (r_state)
            S_CLEAR: begin
                lab_we = 1'b1;
            end
            S_SCAN_CHK: begin
                lab_waddr = scan_a;
                lab_wdata = r_count + 12'd1;
                q_waddr   = '0;
                if (cand && (r_count < 12'(tbl_pkg::MAX_COMP))) begin
                    lab_we = 1'b1;
                    q_we   = 1'b1;
                end
            end
            S_NB_CHK: begin
                lab_waddr = r_na;
                lab_wdata = r_lab;
                if (cand && !r_tail[CAW]) begin
                    lab_we = 1'b1;
                    q_we   = 1'b1;
                end
            end
            default: ;
        endcase

        case (r_state)
            S_IDLE:     lab_raddr = {i_in_data.cell_y, i_in_data.cell_x};
            S_RD_WAIT:  lab_raddr = r_addr;
            S_NB_ISSUE: lab_raddr = na;
            default:    lab_raddr = scan_a;
        endcase

        q_raddr   = r_head[CAW-1:0];
        rec_we    = (r_state == S_REC_WR);
        rec_waddr = tbl_pkg::COMP_AW'(r_lab - 12'd1);
        rec_raddr = (r_state == S_IDLE)
                    ? tbl_pkg::COMP_AW'(i_in_data.component_number - 12'd1)
                    : tbl_pkg::COMP_AW'(r_num - 12'd1);
    end

    // queue data holds the cell index written
    logic [CAW-1:0] q_wdata;
    assign q_wdata = (r_state == S_SCAN_CHK) ? scan_a : r_na;

    tbl_ram #(.WIDTH(16), .DEPTH(tbl_pkg::CELLS)) u_sample (
        .i_clk(i_clk), .i_we(smp_we), .i_waddr(smp_waddr), .i_wdata(i_in_data.sample),
        .i_raddr(smp_raddr), .o_rdata(smp_rdata)
    );
    tbl_ram #(.WIDTH(tbl_pkg::LAB_W), .DEPTH(tbl_pkg::CELLS)) u_label (
        .i_clk(i_clk), .i_we(lab_we), .i_waddr(lab_waddr), .i_wdata(lab_wdata),
        .i_raddr(lab_raddr), .o_rdata(lab_rdata)
    );
    tbl_ram #(.WIDTH(CAW), .DEPTH(tbl_pkg::CELLS)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata)
    );
    tbl_ram #(.WIDTH($bits(tbl_pkg::t_rec)), .DEPTH(tbl_pkg::MAX_COMP)) u_rec (
        .i_clk(i_clk), .i_we(rec_we), .i_waddr(rec_waddr), .i_wdata(r_rec),
        .i_raddr(rec_raddr), .o_rdata(rec_rdata)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= 7'd64;
            r_cfg_h <= 7'd64;
            r_thr   <= 16'sd0;
            r_eight <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tbl_pkg::CFG_WIDTH:  r_cfg_w <= i_cfg_data[6:0];
                tbl_pkg::CFG_HEIGHT: r_cfg_h <= i_cfg_data[6:0];
                tbl_pkg::CFG_THRESH: r_thr   <= $signed(i_cfg_data);
                tbl_pkg::CFG_EIGHT:  r_eight <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // current cell sample for accumulation, sign extended
    logic signed [27:0] v_ext;
    assign v_ext = 28'(smp_rdata);

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= 12'd0;
            r_ran       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // output register fills from the read state, empties on its beat
            if ((r_state == S_RD_WAIT) && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op   <= i_in_data.opcode;
                        r_addr <= {i_in_data.cell_y, i_in_data.cell_x};
                        r_num  <= i_in_data.component_number;
                        case (i_in_data.opcode)
                            tbl_pkg::OP_RUN: begin
                                r_clr   <= '0;
                                r_ran   <= 1'b1;
                                r_state <= S_CLEAR;
                            end
                            tbl_pkg::OP_READ_LAB, tbl_pkg::OP_READ_REC: r_state <= S_RD_WAIT;
                            default: ;
                        endcase
                    end
                end
                S_RD_WAIT: begin
                    // result waits here until the output register is free
                    if (!r_out_valid || i_out_ready) begin
                        r_out   <= n_out;
                        r_state <= S_IDLE;
                    end
                end
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) begin
                        r_sx    <= 6'd0;
                        r_sy    <= 6'd0;
                        r_count <= 12'd0;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: r_state <= S_SCAN_CHK;
                S_SCAN_CHK: begin
                    if (cand && (r_count < 12'(tbl_pkg::MAX_COMP))) begin
                        // seed a new component
                        r_count     <= r_count + 12'd1;
                        r_lab       <= r_count + 12'd1;
                        r_head      <= '0;
                        r_tail      <= (CAW+1)'(1);
                        r_rec       <= '{area: 13'd0, peak: 16'sd0, total: 28'sd0,
                                         xs2: 19'd0, ys2: 19'd0,
                                         bx0: r_sx, bx1: r_sx, by0: r_sy, by1: r_sy};
                        r_state     <= S_POP;
                    end else if (scan_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_sx    <= x_last ? 6'd0 : r_sx + 6'd1;
                        r_sy    <= x_last ? r_sy + 6'd1 : r_sy;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_POP: begin
                    if (r_head < r_tail) begin
                        r_head  <= r_head + 1'b1;
                        r_state <= S_POP_WAIT;
                    end else begin
                        r_state <= S_REC_WR;
                    end
                end
                S_POP_WAIT: begin
                    r_cx    <= q_rdata[5:0];
                    r_cy    <= q_rdata[11:6];
                    r_state <= S_CUR_WAIT;
                end
                S_CUR_WAIT: begin
                    r_rec.area  <= r_rec.area + 13'd1;
                    r_rec.total <= r_rec.total + v_ext;
                    if (smp_rdata > r_rec.peak) begin
                        r_rec.peak <= smp_rdata;
                    end
                    r_rec.xs2 <= r_rec.xs2 + {12'd0, r_cx, 1'b1};
                    r_rec.ys2 <= r_rec.ys2 + {12'd0, r_cy, 1'b1};
                    if (r_cx < r_rec.bx0) r_rec.bx0 <= r_cx;
                    if (r_cx > r_rec.bx1) r_rec.bx1 <= r_cx;
                    if (r_cy < r_rec.by0) r_rec.by0 <= r_cy;
                    if (r_cy > r_rec.by1) r_rec.by1 <= r_cy;
                    r_k     <= 3'd0;
                    r_state <= S_NB_ISSUE;
                end
                S_NB_ISSUE: begin
                    if (nb_in) begin
                        r_na    <= na;
                        r_state <= S_NB_CHK;
                    end else if (k_last) begin
                        r_state <= S_POP;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_NB_CHK: begin
                    if (cand && !r_tail[CAW]) begin
                        r_tail <= r_tail + 1'b1;
                    end
                    if (k_last) begin
                        r_state <= S_POP;
                    end else begin
                        r_k     <= r_k + 3'd1;
                        r_state <= S_NB_ISSUE;
                    end
                end
                S_REC_WR: begin
                    if (scan_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_sx    <= x_last ? 6'd0 : r_sx + 6'd1;
                        r_sy    <= x_last ? r_sy + 6'd1 : r_sy;
                        r_state <= S_SCAN_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### tb/sv/blob_checker.sv
module blob_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  tbl_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  tbl_pkg::t_out i_out_data,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    output int            o_errors,
    output int            o_pending
);
    import tbl_pkg::*;

    localparam int EXP_DEPTH = 16;

    typedef struct {
        int area;
        int peak;
        int total;
        int xs2;
        int ys2;
        int bx0;
        int bx1;
        int by0;
        int by1;
    } blob_t;

    logic signed [15:0] cell_value [CELLS];
    int                 cell_tag   [CELLS];
    int                 walk_q     [CELLS];
    blob_t              blobs      [MAX_COMP + 1];
    int                 blob_count;
    logic [6:0]         width_reg;
    logic [6:0]         height_reg;
    logic signed [15:0] thresh_reg;
    logic               eight_reg;
    // expected read results, a small ring with free-running indexes
    t_out               expected_reads [EXP_DEPTH];
    int                 exp_wr = 0;
    int                 exp_rd = 0;

    const int nbr_dx [8] = '{1, -1, 0, 0, 1, 1, -1, -1};
    const int nbr_dy [8] = '{0, 0, 1, -1, 1, -1, 1, -1};

    assign o_pending = exp_wr - exp_rd;

    function automatic int fit_size(input logic [6:0] v);
        if (v == 0) return 1;
        return (v > GRID_DIM) ? GRID_DIM : int'(v);
    endfunction

    // breadth-first walk from each unlabeled active cell in raster order
    task automatic label_grid();
        int w, h, nb, head, tail, cur, cx, cy, nx, ny, na, lab;
        w  = fit_size(width_reg);
        h  = fit_size(height_reg);
        nb = eight_reg ? 8 : 4;
        foreach (cell_tag[i]) cell_tag[i] = 0;
        blob_count = 0;
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                cur = y * GRID_DIM + x;
                if (cell_tag[cur] != 0 || !(cell_value[cur] > thresh_reg)) continue;
                if (blob_count >= MAX_COMP) continue;
                blob_count++;
                lab = blob_count;
                blobs[lab] = '{0, 0, 0, 0, 0, x, x, y, y};
                head = 0;
                tail = 1;
                walk_q[0] = cur;
                cell_tag[cur] = lab;
                while (head < tail) begin
                    cur = walk_q[head];
                    head++;
                    cx = cur % GRID_DIM;
                    cy = cur / GRID_DIM;
                    blobs[lab].area++;
                    blobs[lab].total += int'(cell_value[cur]);
                    if (int'(cell_value[cur]) > blobs[lab].peak)
                        blobs[lab].peak = cell_value[cur];
                    blobs[lab].xs2 += 2 * cx + 1;
                    blobs[lab].ys2 += 2 * cy + 1;
                    if (cx < blobs[lab].bx0) blobs[lab].bx0 = cx;
                    if (cx > blobs[lab].bx1) blobs[lab].bx1 = cx;
                    if (cy < blobs[lab].by0) blobs[lab].by0 = cy;
                    if (cy > blobs[lab].by1) blobs[lab].by1 = cy;
                    for (int k = 0; k < nb; k++) begin
                        nx = cx + nbr_dx[k];
                        ny = cy + nbr_dy[k];
                        if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
                        na = ny * GRID_DIM + nx;
                        if (cell_tag[na] != 0 || !(cell_value[na] > thresh_reg)) continue;
                        cell_tag[na] = lab;
                        walk_q[tail] = na;
                        tail++;
                    end
                end
            end
        end
    endtask

    function automatic t_out read_result(input t_in item);
        t_out r;
        int   num;
        r = '0;
        r.component_count = blob_count[11:0];
        if (item.opcode == OP_READ_LAB) begin
            r.cell_label = cell_tag[item.cell_y * GRID_DIM + item.cell_x][11:0];
        end else begin
            num = item.component_number;
            if (num == 0 || num > blob_count) begin
                r.status = 1'b1;
            end else begin
                r.area          = blobs[num].area[12:0];
                r.max_value     = blobs[num].peak[15:0];
                r.value_sum     = blobs[num].total[27:0];
                r.x_sum_doubled = blobs[num].xs2[18:0];
                r.y_sum_doubled = blobs[num].ys2[18:0];
                r.box_min_x     = blobs[num].bx0[5:0];
                r.box_max_x     = blobs[num].bx1[5:0];
                r.box_min_y     = blobs[num].by0[5:0];
                r.box_max_y     = blobs[num].by1[5:0];
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            foreach (cell_value[i]) cell_value[i] = '0;
            foreach (cell_tag[i]) cell_tag[i] = 0;
            blob_count = 0;
            width_reg  = 7'd64;
            height_reg = 7'd64;
            thresh_reg = '0;
            eight_reg  = 1'b0;
            exp_wr     = 0;
            exp_rd     = 0;
            o_errors   = 0;
        end else begin
            // the result beat is checked first: a read cannot finish in the cycle it starts
            if (i_out_valid && i_out_ready) begin
                if (exp_wr == exp_rd) begin
                    o_errors++;
                    if (o_errors <= 10) $display("unexpected result beat %p", i_out_data);
                end else begin
                    want = expected_reads[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (i_out_data !== want) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("result mismatch\n  expected %p\n  actual   %p",
                                     want, i_out_data);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WIDTH:  width_reg  = i_cfg_data[6:0];
                    CFG_HEIGHT: height_reg = i_cfg_data[6:0];
                    CFG_THRESH: thresh_reg = i_cfg_data;
                    CFG_EIGHT:  eight_reg  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                case (i_in_data.opcode)
                    OP_WRITE:
                        cell_value[i_in_data.cell_y * GRID_DIM + i_in_data.cell_x] =
                            i_in_data.sample;
                    OP_RUN:  label_grid();
                    default: begin
                        expected_reads[exp_wr % EXP_DEPTH] = read_result(i_in_data);
                        exp_wr++;
                    end
                endcase
            end
        end
    end

endmodule

### tb/sv/testbench.sv
module testbench;
    import tbl_pkg::*;

    // a run clears 4096 labels and walks the grid; the limit covers many slow runs
    localparam int CYCLE_LIMIT = 20_000_000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in         in_data;
    logic        out_valid;
    logic        out_ready;
    t_out        out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    int          errors;
    int          pending;
    int          cycles;

    // idle mode: 0 none, 1 sender idles, 2 receiver stalls, 3 both
    int          idle_mode;
    // grid in use and threshold as the stimulus sees them
    int          grid_w;
    int          grid_h;
    int          thresh;

    threshold_blob_labeling dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    blob_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver stalls depending on the idle mode
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (idle_mode == 2) begin
            out_ready <= ($urandom_range(99) >= 88);
        end else if (idle_mode == 3) begin
            out_ready <= ($urandom_range(99) >= 30);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // one input beat; valid stays high afterwards unless a gap comes next
    task automatic send(input t_in item);
        int gap;
        gap = 0;
        if (idle_mode == 1) begin
            while ($urandom_range(99) < 88) gap++;
        end else if (idle_mode == 3) begin
            while ($urandom_range(99) < 30) gap++;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_op(input logic [1:0] op, input int x, input int y,
                           input int value, input int num);
        t_in item;
        item.opcode           = op;
        item.cell_x           = x[5:0];
        item.cell_y           = y[5:0];
        item.sample           = value[15:0];
        item.component_number = num[11:0];
        send(item);
    endtask

    // wait out every outstanding result, then the tail of any walk
    task automatic drain();
        in_valid <= 1'b0;
        // let the checker count the last accepted beat before pending is polled
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // all four registers, back to back; block is idle here
    task automatic set_regs(input int w_raw, input int h_raw, input int thr,
                            input bit eight);
        int vals [4];
        vals = '{w_raw, h_raw, thr, eight};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= i[1:0];
            cfg_data  <= vals[i][15:0];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        grid_w = (w_raw[6:0] == 0) ? 1 : (w_raw[6:0] > GRID_DIM ? GRID_DIM : w_raw[6:0]);
        grid_h = (h_raw[6:0] == 0) ? 1 : (h_raw[6:0] > GRID_DIM ? GRID_DIM : h_raw[6:0]);
        thresh = $signed(thr[15:0]);
    endtask

    // mostly values just around the threshold so blobs form and touch
    function automatic int pick_sample();
        int v;
        if ($urandom_range(3) == 0) return $signed(16'($urandom()));
        v = thresh + $urandom_range(6) - 3;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    // every cell of the grid in use gets written before any run
    task automatic fill_grid();
        for (int y = 0; y < grid_h; y++)
            for (int x = 0; x < grid_w; x++)
                send_op(OP_WRITE, x, y, pick_sample(), 0);
    endtask

    task automatic random_ops(input int count);
        int r;
        int num;
        send_op(OP_RUN, 0, 0, 0, 0);
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            // now and then hold back until every read has returned
            if ($urandom_range(49) == 0) drain();
            if (r < 45) begin
                if ($urandom_range(4) != 0)
                    send_op(OP_WRITE, $urandom_range(grid_w - 1), $urandom_range(grid_h - 1),
                            pick_sample(), $urandom());
                else
                    send_op(OP_WRITE, $urandom_range(63), $urandom_range(63),
                            pick_sample(), $urandom());
            end else if (r < 48) begin
                send_op(OP_RUN, $urandom(), $urandom(), $urandom(), $urandom());
            end else if (r < 74) begin
                send_op(OP_READ_LAB, $urandom_range(63), $urandom_range(63),
                        $urandom(), $urandom());
            end else begin
                num = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(40);
                send_op(OP_READ_REC, $urandom(), $urandom(), $urandom(), num);
            end
        end
        // a final read cannot be taken until any run has finished
        send_op(OP_READ_LAB, 0, 0, 0, 0);
        drain();
    endtask

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        cycles    = 0;
        idle_mode = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: small grid, reads before any run, sample extremes
        set_regs(5, 4, 0, 1'b0);
        send_op(OP_READ_LAB, 2, 2, 0, 0);
        send_op(OP_READ_REC, 0, 0, 0, 1);
        send_op(OP_READ_REC, 0, 0, 0, 0);
        for (int y = 0; y < 4; y++)
            for (int x = 0; x < 5; x++)
                send_op(OP_WRITE, x, y, ((x + y) % 2 == 0) ? -1 : 1, 0);
        send_op(OP_WRITE, 0, 0, 32767, 0);
        send_op(OP_WRITE, 4, 3, -32768, 0);
        send_op(OP_WRITE, 1, 0, 0, 0);            // equal to threshold: inactive
        send_op(OP_WRITE, 63, 63, 32767, 0);      // outside the grid in use
        send_op(OP_RUN, 0, 0, 0, 0);
        send_op(OP_READ_LAB, 0, 0, 0, 0);
        send_op(OP_READ_LAB, 63, 63, 0, 0);
        send_op(OP_READ_REC, 0, 0, 0, 1);
        send_op(OP_READ_REC, 0, 0, 0, 0);
        send_op(OP_READ_REC, 0, 0, 0, 4095);
        drain();

        // eight-connected run on the same data joins the diagonals
        set_regs(5, 4, 0, 1'b1);
        send_op(OP_READ_LAB, 1, 1, 0, 0);         // still the old labels
        random_ops(40);

        for (int phase = 0; phase < 8; phase++) begin
            idle_mode = phase % 4;
            case (phase)
                0: set_regs(8, 8, 0, 1'b0);
                1: set_regs(127, 0, -256, 1'b1);   // saturates to 64 x 1
                2: set_regs(0, 64, 256, 1'b0);     // saturates to 1 x 64
                3: set_regs(12, 10, $urandom_range(65535), 1'b1);
                4: set_regs(6, 6, -32768, 1'b0);
                5: set_regs(6, 6, 32767, 1'b1);
                6: set_regs(64, 2, $urandom_range(65535), 1'b0);
                default: set_regs(9, 7, -1, 1'b1);
            endcase
            send_op(OP_READ_REC, 0, 0, 0, 1);
            fill_grid();
            random_ops(170);
        end

        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
